FILE: hdl/ecpr_pkg.sv
package ecpr_pkg;

    // Fixed field widths
    localparam int SLOT_W = 4;
    localparam int OP_W   = 2;
    localparam int KIND_W = 2;

    // Parameter defaults
    localparam int FRAMES_DEF    = 16;
    localparam int PAGE_BITS_DEF = 20;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_ACCESS = 2'd1;
    localparam logic [OP_W-1:0] OP_EVICT  = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_WRITEBACK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VICTIM    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACK       = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR     = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture the input item
        logic ins;         // insert page at the fill point
        logic err;         // emit an error result
        logic acc_set;     // mark slot, read its page
        logic acc_emit;    // emit access acknowledge
        logic walk_start;  // wrap hand into the filled range
        logic walk_rd;     // read the page under the hand
        logic walk_chk;    // judge the frame under the hand
    } ecpr_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            slot_bad;
        logic            victim;
    } ecpr_stat_t;

endpackage

FILE: hdl/ecpr_ctrl.sv
module ecpr_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  ecpr_pkg::ecpr_stat_t stat,
    output ecpr_pkg::ecpr_cmd_t  cmd,
    output logic               busy
);
    import ecpr_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_ACC_RD   = 3'd2;
    localparam logic [2:0] S_WALK_RD  = 3'd3;
    localparam logic [2:0] S_WALK_CHK = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                case (stat.op)
                    OP_INSERT:
                    begin
                        if (stat.full)
                        begin
                            cmd.err = 1'b1;
                        end
                        else
                        begin
                            cmd.ins = 1'b1;
                        end
                    end
                    OP_ACCESS:
                    begin
                        if (stat.slot_bad)
                        begin
                            cmd.err = 1'b1;
                        end
                        else
                        begin
                            cmd.acc_set = 1'b1;
                            state_next  = S_ACC_RD;
                        end
                    end
                    OP_EVICT:
                    begin
                        if (stat.empty)
                        begin
                            cmd.err = 1'b1;
                        end
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK_RD;
                        end
                    end
                    default:
                    begin
                        cmd.err = 1'b1;
                    end
                endcase
            end
            S_ACC_RD:
            begin
                cmd.acc_emit = 1'b1;
                state_next   = S_IDLE;
            end
            S_WALK_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                cmd.walk_chk = 1'b1;
                state_next   = stat.victim ? S_IDLE : S_WALK_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/ecpr_datapath.sv
module ecpr_datapath
#(
    parameter int FRAMES    = ecpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = ecpr_pkg::PAGE_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ecpr_pkg::ecpr_cmd_t         cmd,
    output ecpr_pkg::ecpr_stat_t        stat,
    input  logic [ecpr_pkg::OP_W-1:0]   operation,
    input  logic [ecpr_pkg::SLOT_W-1:0] slot,
    input  logic [PAGE_BITS-1:0]        page_number,
    input  logic                        is_write,
    output logic                        strobe,
    output logic [ecpr_pkg::KIND_W-1:0] kind,
    output logic [ecpr_pkg::SLOT_W-1:0] frame_slot,
    output logic [PAGE_BITS-1:0]        page_out,
    output logic                        last
);
    import ecpr_pkg::*;

    localparam int IDX_W = $clog2(FRAMES);
    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    // Captured item
    logic [OP_W-1:0]      op_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [PAGE_BITS-1:0] page_reg;
    logic                 wr_reg;

    // Ring state
    logic [PAGE_BITS-1:0] mem [FRAMES];
    logic [FRAMES-1:0]    acc_reg;
    logic [FRAMES-1:0]    dirty_reg;
    logic [CNT_W-1:0]     used_reg;
    logic [IDX_W-1:0]     hand_reg;
    logic [PAGE_BITS-1:0] rd_data_reg;

    // Result registers
    logic                 strobe_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [SLOT_W-1:0]    fslot_reg;
    logic [PAGE_BITS-1:0] pout_reg;
    logic                 last_reg;

    logic [IDX_W-1:0]     slot_idx;
    logic [IDX_W-1:0]     fill_idx;
    logic [IDX_W-1:0]     hand_inc;
    logic                 hand_a;
    logic                 hand_d;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [PAGE_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_raddr;

    assign slot_idx = IDX_W'(slot_reg);
    assign fill_idx = used_reg[IDX_W-1:0];
    assign hand_a   = acc_reg[hand_reg];
    assign hand_d   = dirty_reg[hand_reg];
    assign hand_inc = ((CNT_W'(hand_reg) + CNT_W'(1)) == used_reg) ? '0
                                                                    : hand_reg + IDX_W'(1);

    // Status
    always_comb
    begin
        stat.op       = op_reg;
        stat.full     = (used_reg >= CNT_W'(FRAMES));
        stat.empty    = (used_reg == '0);
        stat.slot_bad = (CMP_W'(slot_reg) >= CMP_W'(used_reg));
        stat.victim   = !hand_a && !hand_d;
    end

    // Page memory ports
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = hand_reg;
        mem_wdata = page_reg;
        if (cmd.ins)
        begin
            mem_we    = 1'b1;
            mem_waddr = fill_idx;
        end
        else if (cmd.walk_chk && !hand_a && !hand_d)
        begin
            mem_we = 1'b1;
        end
        mem_re    = cmd.acc_set || cmd.walk_rd;
        mem_raddr = cmd.acc_set ? slot_idx : hand_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= operation;
            slot_reg <= slot;
            page_reg <= page_number;
            wr_reg   <= is_write;
        end
    end

    // Frame bits, fill count and hand
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            dirty_reg <= '0;
            used_reg  <= '0;
            hand_reg  <= '0;
        end
        else
        begin
            if (cmd.ins)
            begin
                acc_reg[fill_idx]   <= 1'b0;
                dirty_reg[fill_idx] <= 1'b0;
                used_reg            <= used_reg + CNT_W'(1);
            end
            if (cmd.acc_set)
            begin
                acc_reg[slot_idx] <= 1'b1;
                if (wr_reg)
                begin
                    dirty_reg[slot_idx] <= 1'b1;
                end
            end
            if (cmd.walk_start && (CNT_W'(hand_reg) >= used_reg))
            begin
                hand_reg <= '0;
            end
            if (cmd.walk_chk)
            begin
                hand_reg <= hand_inc;
                if (hand_a)
                begin
                    acc_reg[hand_reg] <= 1'b0;
                end
                else if (hand_d)
                begin
                    dirty_reg[hand_reg] <= 1'b0;
                end
                else
                begin
                    acc_reg[hand_reg]   <= 1'b1;
                    dirty_reg[hand_reg] <= wr_reg;
                end
            end
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.ins || cmd.err || cmd.acc_emit
                          || (cmd.walk_chk && !hand_a);
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.ins)
        begin
            kind_reg  <= KIND_ACK;
            fslot_reg <= SLOT_W'(used_reg);
            pout_reg  <= page_reg;
            last_reg  <= 1'b1;
        end
        else if (cmd.err)
        begin
            kind_reg  <= KIND_ERROR;
            fslot_reg <= (op_reg == OP_ACCESS) ? slot_reg : '0;
            pout_reg  <= '0;
            last_reg  <= 1'b1;
        end
        else if (cmd.acc_emit)
        begin
            kind_reg  <= KIND_ACK;
            fslot_reg <= slot_reg;
            pout_reg  <= rd_data_reg;
            last_reg  <= 1'b1;
        end
        else if (cmd.walk_chk && !hand_a)
        begin
            kind_reg  <= hand_d ? KIND_WRITEBACK : KIND_VICTIM;
            fslot_reg <= SLOT_W'(hand_reg);
            pout_reg  <= rd_data_reg;
            last_reg  <= !hand_d;
        end
    end

    assign strobe     = strobe_reg;
    assign kind       = kind_reg;
    assign frame_slot = fslot_reg;
    assign page_out   = pout_reg;
    assign last       = last_reg;

endmodule

FILE: hdl/enhanced_clock_page_replacement_top.sv
// Enhanced second-chance clock page replacement. An item is taken when start
// is high while busy is low; each result appears for exactly one cycle with
// strobe high and must be captured then, since the receiver cannot stall the
// block. Inserts, errors and failed lookups are settled in the decode state,
// while an access adds one page-memory read before its result. An evict sets
// up the hand and then, for each frame visited by the hand, does one
// page-memory read and one check; the hand visits at most 2*FRAMES+1 frames.
// Writeback results come out as the walk passes dirty frames whose accessed
// bit is clear, with last low, and the victim result closes the item. busy
// drops in the cycle the final result is strobed, so one item is handled at
// a time.
module enhanced_clock_page_replacement_top
#(
    parameter int FRAMES    = ecpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = ecpr_pkg::PAGE_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ecpr_pkg::OP_W-1:0]   operation,
    input  logic [ecpr_pkg::SLOT_W-1:0] slot,
    input  logic [PAGE_BITS-1:0]        page_number,
    input  logic                        is_write,
    output logic                        strobe,
    output logic [ecpr_pkg::KIND_W-1:0] kind,
    output logic [ecpr_pkg::SLOT_W-1:0] frame_slot,
    output logic [PAGE_BITS-1:0]        page_out,
    output logic                        last
);
    import ecpr_pkg::*;

    ecpr_cmd_t  cmd;
    ecpr_stat_t stat;

    // Sequencer
    ecpr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Ring storage and result registers
    ecpr_datapath
    #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .operation   (operation),
        .slot        (slot),
        .page_number (page_number),
        .is_write    (is_write),
        .strobe      (strobe),
        .kind        (kind),
        .frame_slot  (frame_slot),
        .page_out    (page_out),
        .last        (last)
    );

endmodule

FILE: test/ecpr_checker.sv
module ecpr_checker
#(
    parameter int FRAMES    = ecpr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = ecpr_pkg::PAGE_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [ecpr_pkg::OP_W-1:0]   operation,
    input  logic [ecpr_pkg::SLOT_W-1:0] slot,
    input  logic [PAGE_BITS-1:0]        page_number,
    input  logic                        is_write,
    input  logic                        strobe,
    input  logic [ecpr_pkg::KIND_W-1:0] kind,
    input  logic [ecpr_pkg::SLOT_W-1:0] frame_slot,
    input  logic [PAGE_BITS-1:0]        page_out,
    input  logic                        last,
    output int                          mismatches,
    output int                          outstanding,
    output int                          results_seen,
    output int                          writebacks_seen,
    output int                          victims_seen
);
    import ecpr_pkg::*;

    localparam int PRINT_CAP = 20;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [SLOT_W-1:0]    fslot;
        logic [PAGE_BITS-1:0] page;
        logic                 fin;
    } frame_result_t;

    // Shadow copy of the ring
    logic [PAGE_BITS-1:0] frame_page [FRAMES];
    logic [FRAMES-1:0]    frame_accessed;
    logic [FRAMES-1:0]    frame_dirty;
    logic [SLOT_W:0]      frames_filled;
    logic [SLOT_W-1:0]    hand_at;

    frame_result_t awaited_results [$];

    task automatic flag_mismatch(string what, longint unsigned want, longint unsigned got);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
    endtask

    function automatic void await_result(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] s,
                                         logic [PAGE_BITS-1:0] p, logic f);
        frame_result_t r;
        r.kind  = k;
        r.fslot = s;
        r.page  = p;
        r.fin   = f;
        awaited_results.push_back(r);
    endfunction

    // Apply one item to the shadow ring and queue the results it causes
    function automatic void apply_page_op(logic [OP_W-1:0] op, logic [SLOT_W-1:0] s,
                                          logic [PAGE_BITS-1:0] pg, logic wr);
        int  n;
        int  h;
        int  steps;
        bit  found;
        n     = int'(frames_filled);
        found = 1'b0;
        case (op)
            OP_INSERT:
            begin
                if (n >= FRAMES)
                    await_result(KIND_ERROR, '0, '0, 1'b1);
                else
                begin
                    frame_page[n]     = pg;
                    frame_accessed[n] = 1'b0;
                    frame_dirty[n]    = 1'b0;
                    await_result(KIND_ACK, SLOT_W'(n), pg, 1'b1);
                    frames_filled     = frames_filled + 1'b1;
                end
            end
            OP_ACCESS:
            begin
                if (int'(s) >= n)
                    await_result(KIND_ERROR, s, '0, 1'b1);
                else
                begin
                    frame_accessed[s] = 1'b1;
                    if (wr)
                        frame_dirty[s] = 1'b1;
                    await_result(KIND_ACK, s, frame_page[s], 1'b1);
                end
            end
            OP_EVICT:
            begin
                if (n == 0)
                    await_result(KIND_ERROR, '0, '0, 1'b1);
                else
                begin
                    if (int'(hand_at) >= n)
                        hand_at = '0;
                    // clock walk: clean frame wins, dirty-only is written back,
                    // accessed loses its second chance
                    for (steps = 0; steps < 3 * n + 1 && !found; steps++)
                    begin
                        h = int'(hand_at);
                        if (!frame_accessed[h] && !frame_dirty[h])
                        begin
                            await_result(KIND_VICTIM, SLOT_W'(h), frame_page[h], 1'b1);
                            frame_page[h]     = pg;
                            frame_accessed[h] = 1'b1;
                            frame_dirty[h]    = wr;
                            found             = 1'b1;
                        end
                        else if (!frame_accessed[h])
                        begin
                            await_result(KIND_WRITEBACK, SLOT_W'(h), frame_page[h], 1'b0);
                            frame_dirty[h] = 1'b0;
                        end
                        else
                            frame_accessed[h] = 1'b0;
                        hand_at = SLOT_W'((h + 1) % n);
                    end
                end
            end
            default:
                await_result(KIND_ERROR, '0, '0, 1'b1);
        endcase
    endfunction

    // Compare results first, then take the item accepted at this edge
    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < FRAMES; i++)
                frame_page[i] = '0;
            frame_accessed = '0;
            frame_dirty    = '0;
            frames_filled  = '0;
            hand_at        = '0;
            awaited_results.delete();
            outstanding    = 0;
        end
        else
        begin
            if (strobe)
            begin
                results_seen++;
                if (kind == KIND_WRITEBACK)
                    writebacks_seen++;
                if (kind == KIND_VICTIM)
                    victims_seen++;
                if (awaited_results.size() == 0)
                    flag_mismatch("unexpected result kind", 0, kind);
                else
                begin
                    want = awaited_results.pop_front();
                    if (kind !== want.kind)
                        flag_mismatch("kind", want.kind, kind);
                    if (frame_slot !== want.fslot)
                        flag_mismatch("frame_slot", want.fslot, frame_slot);
                    if (page_out !== want.page)
                        flag_mismatch("page_out", want.page, page_out);
                    if (last !== want.fin)
                        flag_mismatch("last", want.fin, last);
                end
            end
            if (start && !busy)
                apply_page_op(operation, slot, page_number, is_write);
            outstanding = awaited_results.size();
        end
    end

endmodule

FILE: test/tb.sv
module tb;
    import ecpr_pkg::*;

    localparam int FRAMES        = FRAMES_DEF;
    localparam int PAGE_BITS     = PAGE_BITS_DEF;
    localparam int RANDOM_ITEMS  = 250;
    localparam int STALL_LIMIT   = 2000;
    // one full evict walk plus setup
    localparam int SETTLE_CYCLES = 2 * (2 * FRAMES + 1) + 8;

    localparam logic [OP_W-1:0]      OP_UNDEFINED = 2'd3;
    localparam logic [PAGE_BITS-1:0] PAGE_MAX     = '1;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [OP_W-1:0]      operation;
    logic [SLOT_W-1:0]    slot;
    logic [PAGE_BITS-1:0] page_number;
    logic                 is_write;
    logic                 strobe;
    logic [KIND_W-1:0]    kind;
    logic [SLOT_W-1:0]    frame_slot;
    logic [PAGE_BITS-1:0] page_out;
    logic                 last;

    int mismatches;
    int outstanding;
    int results_seen;
    int writebacks_seen;
    int victims_seen;

    int filled_guess = 0;
    int ops_sent [4] = '{0, 0, 0, 0};
    int quiet_cycles = 0;
    bit steady       = 1'b0;

    enhanced_clock_page_replacement_top #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .slot        (slot),
        .page_number (page_number),
        .is_write    (is_write),
        .strobe      (strobe),
        .kind        (kind),
        .frame_slot  (frame_slot),
        .page_out    (page_out),
        .last        (last)
    );

    ecpr_checker #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .operation       (operation),
        .slot            (slot),
        .page_number     (page_number),
        .is_write        (is_write),
        .strobe          (strobe),
        .kind            (kind),
        .frame_slot      (frame_slot),
        .page_out        (page_out),
        .last            (last),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_seen    (results_seen),
        .writebacks_seen (writebacks_seen),
        .victims_seen    (victims_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Watchdog: nothing taken in and nothing coming out for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("[enhanced_clock_page_replacement_top] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // mostly short gaps, now and then a long one
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly filled slots, sometimes any slot
    function automatic logic [SLOT_W-1:0] random_slot();
        if (filled_guess > 0 && $urandom_range(0, 9) < 8)
            return SLOT_W'($urandom_range(0, filled_guess - 1));
        return SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
    endfunction

    function automatic logic [PAGE_BITS-1:0] random_page();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return PAGE_MAX;
        return PAGE_BITS'($urandom());
    endfunction

    task automatic hold_off(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Present one item and hold it until it is taken
    task automatic send_op(logic [OP_W-1:0] op, logic [SLOT_W-1:0] s,
                           logic [PAGE_BITS-1:0] pg, logic wr);
        @(negedge clk);
        start       <= 1'b1;
        operation   <= op;
        slot        <= s;
        page_number <= pg;
        is_write    <= wr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ops_sent[op]++;
        if (op == OP_INSERT && filled_guess < FRAMES)
            filled_guess++;
        if (!steady)
            hold_off(random_gap());
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        while (outstanding != 0);
    endtask

    initial
    begin
        int              pick;
        logic [OP_W-1:0] op;

        rst_n       = 1'b0;
        start       = 1'b0;
        operation   = OP_INSERT;
        slot        = '0;
        page_number = '0;
        is_write    = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // empty ring: evict, access and an undefined op are all refused
        send_op(OP_EVICT, '0, PAGE_MAX, 1'b1);
        send_op(OP_ACCESS, '0, '0, 1'b0);
        send_op(OP_UNDEFINED, '1, PAGE_MAX, 1'b1);

        // three frames, page extremes; slot is a don't-care on insert
        send_op(OP_INSERT, '1, '0, 1'b1);
        send_op(OP_INSERT, '0, PAGE_MAX, 1'b0);
        send_op(OP_INSERT, 4'd7, 20'h5A5A5, 1'b0);

        // unfilled slots are refused
        send_op(OP_ACCESS, '1, PAGE_MAX, 1'b1);
        send_op(OP_ACCESS, 4'd3, '0, 1'b0);

        // slot 1 accessed and dirty, slot 0 accessed
        send_op(OP_ACCESS, 4'd1, '0, 1'b1);
        send_op(OP_ACCESS, 4'd0, PAGE_MAX, 1'b0);

        // walk clears two accessed bits, takes clean slot 2, hand wraps
        send_op(OP_EVICT, 4'd9, 20'hABCDE, 1'b1);
        // slot 0 lost its accessed bit, so it goes straight away
        send_op(OP_EVICT, '0, 20'h12345, 1'b0);
        // slot 1 is dirty only: writeback, then a second pass finds it clean
        send_op(OP_EVICT, '1, 20'h00F0F, 1'b1);

        send_op(OP_UNDEFINED, 4'd5, 20'h80001, 1'b0);
        send_op(OP_INSERT, '0, 20'h7FFFE, 1'b1);
        send_op(OP_ACCESS, 4'd3, random_page(), 1'b1);
        send_op(OP_EVICT, 4'd2, PAGE_MAX, 1'b0);

        // random mix, ring filling gradually through inserts
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 32 == 0)
                steady = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_ITEMS / 2)
                wait_drained();
            pick = $urandom_range(0, 99);
            if (pick < 12)
                op = OP_INSERT;
            else if (pick < 67)
                op = OP_ACCESS;
            else if (pick < 95)
                op = OP_EVICT;
            else
                op = OP_UNDEFINED;
            send_op(op, random_slot(), random_page(), 1'($urandom_range(0, 1)));
        end

        // full ring, then an insert that must be refused
        steady = 1'b0;
        while (filled_guess < FRAMES)
            send_op(OP_INSERT, random_slot(), random_page(), 1'b0);
        send_op(OP_INSERT, random_slot(), random_page(), 1'b1);

        // longest walk: every frame accessed and dirty
        for (int i = 0; i < FRAMES; i++)
            send_op(OP_ACCESS, SLOT_W'(i), random_page(), 1'b1);
        send_op(OP_EVICT, random_slot(), PAGE_MAX, 1'b1);

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d inserts, %0d accesses, %0d evicts, %0d undefined ops",
                 ops_sent[OP_INSERT], ops_sent[OP_ACCESS], ops_sent[OP_EVICT],
                 ops_sent[OP_UNDEFINED]);
        $display("Checked %0d results (%0d writebacks, %0d victims), %0d mismatches",
                 results_seen, writebacks_seen, victims_seen, mismatches);
        if (mismatches == 0)
            $display("[enhanced_clock_page_replacement_top] OK");
        else
            $display("[enhanced_clock_page_replacement_top] ERROR");
        $finish;
    end

endmodule
